@@ design/bme_pkg.sv @@
`timescale 1ns / 1ps
// bme_pkg: shared constants of the board evaluator, widths, field codes and defaults
// no dependencies

package bme_pkg;

	// default network shape
	localparam int INPUT_WIDTH_DEF   = 384;
	localparam int FIRST_HIDDEN_DEF  = 8;
	localparam int SECOND_HIDDEN_DEF = 4;

	// stream words
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 16;

	// item fields
	localparam int WIDX_W   = 12;
	localparam int WORD_W   = 16;
	localparam int SQUARE_W = 6;
	localparam int PLANE_W  = 3;

	// action codes carried in tuser
	localparam logic ACT_WEIGHT = 1'b0;
	localparam logic ACT_SQUARE = 1'b1;

	// configuration registers
	localparam int          CFG_IDX_W        = 1;
	localparam int          SLOPE_W          = 13;
	localparam logic [0:0]  CFG_SLOPE_FIRST  = 1'b0;
	localparam logic [0:0]  CFG_SLOPE_SECOND = 1'b1;
	localparam logic [12:0] SLOPE_RESET      = 13'd410;

	// datapath widths
	localparam int SUM_W   = 32;
	localparam int H1_W    = 35;
	localparam int H2_W    = 42;
	localparam int MUL_A_W = 48;
	localparam int ACC_W   = 64;
	localparam int MAG_W   = 57;
	localparam int FRAC    = 12;

	localparam logic signed [ACC_W-1:0] H2_LIMIT   = 64'sd1 <<< 40;
	localparam logic signed [ACC_W-1:0] ACC3_LIMIT = 64'sd1 <<< 56;

endpackage

@@ design/board_mlp_evaluator.sv @@
`timescale 1ns / 1ps
// board_mlp_evaluator: fixed-point perceptron scoring a chess board, weight store inside
// depends on bme_pkg
//
// channel  dir  fields (low bit up)
// s_*      in   tdata: weight_index, weight_value, square, piece_present, piece_plane,
//               piece_white; tuser: action; tlast: last_square
// m_*      out  tdata: score_centipawns
// cfg_*    in   write of slope_first (index 0) or slope_second (index 1)
//
// a weight word, or a square without a counted piece, needs no further work; a counted piece
// makes one store read and one add per hidden sum, and no new item is taken meanwhile
// the last square adds the evaluation through the single shared 48x16 multiplier
// reset clears the sums and sets both slopes to SLOPE_RESET; the weight store is undefined until written
// one finished score waits in the output register; a further evaluation holds at its
// final step until that score is taken

module board_mlp_evaluator #(
	parameter int INPUT_WIDTH   = bme_pkg::INPUT_WIDTH_DEF,
	parameter int FIRST_HIDDEN  = bme_pkg::FIRST_HIDDEN_DEF,
	parameter int SECOND_HIDDEN = bme_pkg::SECOND_HIDDEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// weight_index[11:0], weight_value[27:12], square[33:28], piece_present[34],
	// piece_plane[37:35], piece_white[38], zero[39]
	input  logic [bme_pkg::IN_DATA_W-1:0]     s_tdata,
	// action[0]
	input  logic                              s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// score_centipawns[15:0]
	output logic [bme_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_we,
	input  logic [bme_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bme_pkg::SLOPE_W-1:0]       cfg_data
);
	import bme_pkg::*;

	localparam int BIAS1_BASE  = INPUT_WIDTH * FIRST_HIDDEN;
	localparam int LAYER2_BASE = BIAS1_BASE + FIRST_HIDDEN;
	localparam int BIAS2_BASE  = LAYER2_BASE + SECOND_HIDDEN * FIRST_HIDDEN;
	localparam int LAYER3_BASE = BIAS2_BASE + SECOND_HIDDEN;
	localparam int BIAS3_BASE  = LAYER3_BASE + SECOND_HIDDEN;
	localparam int STORE_DEPTH = BIAS3_BASE + 1;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int FIW         = (FIRST_HIDDEN > 1) ? $clog2(FIRST_HIDDEN) : 1;
	localparam int SIW         = (SECOND_HIDDEN > 1) ? $clog2(SECOND_HIDDEN) : 1;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_ACC  = 9'b000000010,
		S_H1   = 9'b000000100,
		S_L2B  = 9'b000001000,
		S_L2M  = 9'b000010000,
		S_L2H  = 9'b000100000,
		S_L3B  = 9'b001000000,
		S_L3M  = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [1:0]     ph_q;
	logic [FIW-1:0] i_q;
	logic [SIW-1:0] j_q;
	logic [AW-1:0]  addr_q;
	logic           iss_done_q;
	logic           rv_q;
	logic           white_q;
	logic           last_q;
	logic [SLOPE_W-1:0] slope1_q;
	logic [SLOPE_W-1:0] slope2_q;

	logic [WORD_W-1:0] store_mem [STORE_DEPTH];
	logic signed [WORD_W-1:0] rd_q;
	logic [AW-1:0] rd_addr;

	logic signed [H1_W-1:0] ring_q [FIRST_HIDDEN];
	logic signed [H2_W-1:0] h2_ring_q [SECOND_HIDDEN];
	logic signed [H1_W-1:0] ring_in;
	logic                   ring_shift;
	logic                   ring_clr;
	logic                   h2_push;
	logic                   h2_rot;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [WORD_W-1:0]  mul_b;
	logic signed [ACC_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [MUL_A_W-1:0] v_q;
	logic [MAG_W-1:0]          mag_q;
	logic                      neg_q;
	logic [ACC_W-1:0]          m100_q;

	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// input fields
	logic [WIDX_W-1:0]   in_widx;
	logic [WORD_W-1:0]   in_wval;
	logic [SQUARE_W-1:0] in_square;
	logic                in_present;
	logic [PLANE_W-1:0]  in_plane;
	logic                in_white;
	logic [PLANE_W+SQUARE_W-1:0] in_col;

	assign in_widx    = s_tdata[11:0];
	assign in_wval    = s_tdata[27:12];
	assign in_square  = s_tdata[33:28];
	assign in_present = s_tdata[34];
	assign in_plane   = s_tdata[37:35];
	assign in_white   = s_tdata[38];
	assign in_col     = {in_plane, in_square};

	logic in_acc;
	logic store_we;
	logic col_ok;
	logic fin_ld;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign store_we = in_acc && (s_tuser == ACT_WEIGHT)
		&& ({20'd0, in_widx} < 32'(STORE_DEPTH));
	assign col_ok   = in_present && ({23'd0, in_col} < 32'(INPUT_WIDTH));
	assign fin_ld   = (state_q == S_FIN) && (ph_q == 2'd2) && (!out_valid_q || m_tready);

	logic last_i;
	logic last_j;
	assign last_i = (i_q == FIW'(FIRST_HIDDEN - 1));
	assign last_j = (j_q == SIW'(SECOND_HIDDEN - 1));

	// weight store
	always_comb begin
		case (state_q)
			S_H1:    rd_addr = AW'(BIAS1_BASE) + AW'(i_q);
			S_L2B:   rd_addr = AW'(BIAS2_BASE) + AW'(j_q);
			S_L3B:   rd_addr = AW'(BIAS3_BASE);
			default: rd_addr = addr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[AW'(in_widx)] <= in_wval;
		end
		rd_q <= store_mem[rd_addr];
	end

	// datapath terms
	logic signed [SUM_W-1:0] sum_cur;
	logic signed [SUM_W-1:0] sum_new;
	logic signed [SUM_W:0]   v1;
	logic signed [ACC_W-1:0] h1_lk;
	logic signed [ACC_W-1:0] h2_lk;
	logic signed [ACC_W-1:0] h2_cl;
	logic signed [ACC_W-1:0] acc_cl;
	logic                    v_pos;
	logic [ACC_W-1:0]        mag_ext;
	logic [ACC_W-FRAC-13:0]  q_mag;
	logic [OUT_DATA_W-1:0]   score;

	assign sum_cur = ring_q[0][SUM_W-1:0];
	assign sum_new = white_q ? (sum_cur + SUM_W'(rd_q)) : (sum_cur - SUM_W'(rd_q));
	assign v1      = (SUM_W+1)'(sum_cur) + (SUM_W+1)'(rd_q);
	assign v_pos   = !v_q[MUL_A_W-1] && (v_q != '0);
	assign h1_lk   = v_pos ? ACC_W'(v_q) : (prod_q >>> FRAC);
	assign h2_lk   = v_pos ? ACC_W'(v_q) : (prod_q >>> FRAC);
	assign h2_cl   = (h2_lk > H2_LIMIT) ? H2_LIMIT : ((h2_lk < -H2_LIMIT) ? -H2_LIMIT : h2_lk);
	assign acc_cl  = (acc_q > ACC3_LIMIT) ? ACC3_LIMIT
		: ((acc_q < -ACC3_LIMIT) ? -ACC3_LIMIT : acc_q);
	assign mag_ext = ACC_W'(mag_q);
	assign q_mag   = m100_q[ACC_W-1:24];

	always_comb begin
		if (neg_q) begin
			score = (q_mag > 40'd32768) ? 16'h8000 : 16'(-q_mag);
		end else begin
			score = (q_mag > 40'd32767) ? 16'h7fff : q_mag[15:0];
		end
	end

	// shared multiplier operands
	always_comb begin
		case (state_q)
			S_L2M: begin
				mul_a = MUL_A_W'(ring_q[0]);
				mul_b = rd_q;
			end
			S_L3M: begin
				mul_a = MUL_A_W'(h2_ring_q[0]);
				mul_b = rd_q;
			end
			S_L2H: begin
				mul_a = v_q;
				mul_b = WORD_W'(slope2_q);
			end
			default: begin
				mul_a = v_q;
				mul_b = WORD_W'(slope1_q);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ACC_W'(mul_a) * ACC_W'(mul_b);
	end

	// sum ring: entry 0 is the one being worked on
	always_comb begin
		ring_shift = 1'b0;
		ring_in    = ring_q[0];
		h2_push    = 1'b0;
		h2_rot     = 1'b0;
		case (state_q)
			S_ACC: begin
				ring_shift = rv_q;
				ring_in    = H1_W'(sum_new);
			end
			S_H1: begin
				ring_shift = (ph_q == 2'd3);
				ring_in    = H1_W'(h1_lk);
			end
			S_L2M: begin
				ring_shift = (ph_q == 2'd1);
			end
			S_L2H: begin
				h2_push = (ph_q == 2'd2);
			end
			S_L3M: begin
				h2_rot = (ph_q == 2'd1);
			end
			default: begin
				ring_shift = 1'b0;
			end
		endcase
	end
	assign ring_clr = fin_ld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FIRST_HIDDEN; k++) begin
				ring_q[k] <= '0;
			end
		end else if (ring_clr) begin
			for (int k = 0; k < FIRST_HIDDEN; k++) begin
				ring_q[k] <= '0;
			end
		end else if (ring_shift) begin
			for (int k = 0; k < FIRST_HIDDEN - 1; k++) begin
				ring_q[k] <= ring_q[k+1];
			end
			ring_q[FIRST_HIDDEN-1] <= ring_in;
		end
	end

	always_ff @(posedge clk) begin
		if (h2_push || h2_rot) begin
			for (int k = 0; k < SECOND_HIDDEN - 1; k++) begin
				h2_ring_q[k] <= h2_ring_q[k+1];
			end
			h2_ring_q[SECOND_HIDDEN-1] <= h2_push ? H2_W'(h2_cl) : h2_ring_q[0];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope1_q <= SLOPE_RESET;
			slope2_q <= SLOPE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SLOPE_FIRST:  slope1_q <= cfg_data;
				CFG_SLOPE_SECOND: slope2_q <= cfg_data;
				default:          slope1_q <= slope1_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ph_q       <= '0;
			i_q        <= '0;
			j_q        <= '0;
			addr_q     <= '0;
			iss_done_q <= 1'b0;
			rv_q       <= 1'b0;
			white_q    <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					ph_q <= '0;
					i_q  <= '0;
					j_q  <= '0;
					if (in_acc && (s_tuser == ACT_SQUARE)) begin
						white_q <= in_white;
						last_q  <= s_tlast;
						if (col_ok) begin
							state_q    <= S_ACC;
							addr_q     <= AW'(in_col);
							iss_done_q <= 1'b0;
							rv_q       <= 1'b0;
						end else if (s_tlast) begin
							state_q <= S_H1;
						end
					end
				end
				S_ACC: begin
					// one column word read per cycle, added in the cycle after its read
					rv_q <= !iss_done_q;
					if (!iss_done_q) begin
						addr_q <= addr_q + AW'(INPUT_WIDTH);
						i_q    <= i_q + 1'b1;
						if (last_i) begin
							iss_done_q <= 1'b1;
						end
					end
					if (iss_done_q && rv_q) begin
						i_q     <= '0;
						state_q <= last_q ? S_H1 : S_IDLE;
					end
				end
				S_H1: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd1) begin
						v_q <= MUL_A_W'(v1);
					end
					if (ph_q == 2'd3) begin
						i_q <= i_q + 1'b1;
						if (last_i) begin
							i_q     <= '0;
							j_q     <= '0;
							addr_q  <= AW'(LAYER2_BASE);
							state_q <= S_L2B;
						end
					end
				end
				S_L2B: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd1) begin
						acc_q   <= ACC_W'(rd_q) <<< FRAC;
						ph_q    <= '0;
						i_q     <= '0;
						state_q <= S_L2M;
					end
				end
				S_L2M: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd0) begin
						addr_q <= addr_q + 1'b1;
					end
					if (ph_q == 2'd2) begin
						acc_q <= acc_q + prod_q;
						ph_q  <= '0;
						i_q   <= i_q + 1'b1;
						if (last_i) begin
							i_q     <= '0;
							state_q <= S_L2H;
						end
					end
				end
				S_L2H: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd0) begin
						v_q <= MUL_A_W'(acc_q >>> FRAC);
					end
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						j_q  <= j_q + 1'b1;
						if (last_j) begin
							j_q     <= '0;
							state_q <= S_L3B;
						end else begin
							state_q <= S_L2B;
						end
					end
				end
				S_L3B: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd1) begin
						acc_q   <= ACC_W'(rd_q) <<< FRAC;
						addr_q  <= AW'(LAYER3_BASE);
						ph_q    <= '0;
						state_q <= S_L3M;
					end
				end
				S_L3M: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd0) begin
						addr_q <= addr_q + 1'b1;
					end
					if (ph_q == 2'd2) begin
						acc_q <= acc_q + prod_q;
						ph_q  <= '0;
						j_q   <= j_q + 1'b1;
						if (last_j) begin
							j_q     <= '0;
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (ph_q == 2'd0) begin
						neg_q <= acc_cl[ACC_W-1];
						mag_q <= MAG_W'(acc_cl[ACC_W-1] ? -acc_cl : acc_cl);
						ph_q  <= 2'd1;
					end else if (ph_q == 2'd1) begin
						// times 100 as 64 + 32 + 4
						m100_q <= (mag_ext << 6) + (mag_ext << 5) + (mag_ext << 2);
						ph_q   <= 2'd2;
					end else if (fin_ld) begin
						ph_q    <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_ld) begin
			out_data_q <= score;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for board_mlp_evaluator, one file, no external inputs
// depends on bme_pkg and the evaluator rtl; a local fixed-point model predicts each score not given as known

module testbench;
	import bme_pkg::*;

	localparam int N_IN        = INPUT_WIDTH_DEF;
	localparam int FH          = FIRST_HIDDEN_DEF;
	localparam int SH          = SECOND_HIDDEN_DEF;
	localparam int BIAS1_AT    = N_IN * FH;
	localparam int LAYER2_AT   = BIAS1_AT + FH;
	localparam int BIAS2_AT    = LAYER2_AT + SH * FH;
	localparam int LAYER3_AT   = BIAS2_AT + SH;
	localparam int BIAS3_AT    = LAYER3_AT + SH;
	localparam int STORE_WORDS = BIAS3_AT + 1;

	localparam longint H2_CLAMP   = 64'sd1 <<< 40;
	localparam longint ACC3_CLAMP = 64'sd1 <<< 56;

	localparam int CYCLE_LIMIT     = 4_000_000;
	localparam int SETTLE_CYCLES   = 32;
	localparam int TAIL_CYCLES     = 160;
	localparam int SAT_PIECES      = 40;
	localparam int PHASE_ITEMS     = 180;
	localparam int PHASE_SCORES    = 8;
	localparam int RANDOM_PHASES   = 6;

	typedef struct packed {
		logic                act;
		logic [WIDX_W-1:0]   widx;
		logic [WORD_W-1:0]   wval;
		logic [SQUARE_W-1:0] sq;
		logic                pres;
		logic [PLANE_W-1:0]  plane;
		logic                white;
		logic                last;
	} board_item_t;

	typedef struct packed {
		board_item_t it;
		logic        known;
		logic [15:0] score;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [SLOPE_W-1:0]    cfg_data;

	// local copy of the evaluator state
	logic [WORD_W-1:0]  weight_mem [0:STORE_WORDS-1];
	bit                 word_written [0:STORE_WORDS-1];
	logic [31:0]        hidden_sums [0:FH-1];
	logic [SLOPE_W-1:0] slope_first_q;
	logic [SLOPE_W-1:0] slope_second_q;
	int                 ready_cols[$];

	logic [15:0] score_queue[$];
	dir_row_t    directed[$];
	int          preload_cols[$] = '{0, 21, 63, 64 + 42, 128 + 7, 192 + 56, 256 + 33, N_IN - 1};

	int   error_count = 0;
	int   items_sent = 0;
	int   boards_scored = 0;
	int   cycle_count = 0;
	bit   idle_on = 1'b1;
	int   k, row, ph, start_items, start_boards;
	logic [SLOPE_W-1:0] sa, sb;

	int          stall_left;
	int          rx_cycle;
	int          rx_pick;
	bit          rx_steady;
	logic [15:0] expected_score;

	board_mlp_evaluator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		error_count++;
	endtask

	function automatic board_item_t weight_item(input int idx, input logic [15:0] val,
			input bit last);
		board_item_t it;
		it = '0;
		it.act  = ACT_WEIGHT;
		it.widx = WIDX_W'(idx);
		it.wval = val;
		it.last = last;
		return it;
	endfunction

	function automatic board_item_t square_item(input int sq, input bit pres, input int plane,
			input bit white, input bit last);
		board_item_t it;
		it = '0;
		it.act   = ACT_SQUARE;
		it.sq    = SQUARE_W'(sq);
		it.pres  = pres;
		it.plane = PLANE_W'(plane);
		it.white = white;
		it.last  = last;
		return it;
	endfunction

	// mostly small weights so scores stay in range, with extremes now and then
	function automatic logic [15:0] rand_word();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 16'h7FFF;
		if (r == 1)
			return 16'h8000;
		if (r < 4)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 1023)) - 16'd512;
	endfunction

	function automatic longint weight_at(input int addr);
		return longint'($signed(weight_mem[addr]));
	endfunction

	function automatic bit column_ready(input int col);
		int r;
		for (r = 0; r < FH; r++)
			if (!word_written[r * N_IN + col])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic longint leaky_relu(input longint v, input logic [SLOPE_W-1:0] slope);
		if (v > 0)
			return v;
		return (v * longint'(slope)) >>> 12;
	endfunction

	function automatic longint clamp_mag(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic logic [15:0] board_score();
		longint h1 [FH];
		longint h2 [SH];
		longint acc;
		longint mag;
		int     i, j;
		for (i = 0; i < FH; i++)
			h1[i] = leaky_relu(longint'($signed(hidden_sums[i])) + weight_at(BIAS1_AT + i),
				slope_first_q);
		for (j = 0; j < SH; j++) begin
			acc = weight_at(BIAS2_AT + j) * 4096;
			for (i = 0; i < FH; i++)
				acc += weight_at(LAYER2_AT + j * FH + i) * h1[i];
			h2[j] = clamp_mag(leaky_relu(acc >>> 12, slope_second_q), H2_CLAMP);
		end
		acc = weight_at(BIAS3_AT) * 4096;
		for (j = 0; j < SH; j++)
			acc += weight_at(LAYER3_AT + j) * h2[j];
		acc = clamp_mag(acc, ACC3_CLAMP);
		mag = ((acc < 0) ? -acc : acc) * 100;
		mag = mag >>> 24;
		if (acc < 0)
			return (mag > 32768) ? 16'h8000 : 16'(-mag);
		return (mag > 32767) ? 16'h7FFF : 16'(mag);
	endfunction

	function automatic void predict_item(input board_item_t it, output bit scored,
			output logic [15:0] score);
		int          idx, col, i;
		bit          was_ready;
		logic [31:0] w;
		scored = 1'b0;
		score  = '0;
		if (it.act == ACT_WEIGHT) begin
			idx = int'(it.widx);
			if (idx < STORE_WORDS) begin
				col = idx % N_IN;
				was_ready = (idx < BIAS1_AT) && column_ready(col);
				weight_mem[idx] = it.wval;
				word_written[idx] = 1'b1;
				if (idx < BIAS1_AT && !was_ready && column_ready(col))
					ready_cols.push_back(col);
			end
			return;
		end
		col = int'(it.plane) * 64 + int'(it.sq);
		if (it.pres && col < N_IN) begin
			for (i = 0; i < FH; i++) begin
				w = 32'(weight_at(i * N_IN + col));
				if (it.white)
					hidden_sums[i] = hidden_sums[i] + w;
				else
					hidden_sums[i] = hidden_sums[i] - w;
			end
		end
		if (it.last) begin
			score = board_score();
			scored = 1'b1;
			for (i = 0; i < FH; i++)
				hidden_sums[i] = '0;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_word(input board_item_t it, input bit known,
			input logic [15:0] known_score);
		int          gap;
		bit          scored;
		logic [15:0] score;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, it.white, it.plane, it.pres, it.sq, it.wval, it.widx};
		s_tuser  <= it.act;
		s_tlast  <= it.last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_item(it, scored, score);
		if (it.act == ACT_SQUARE || int'(it.widx) < STORE_WORDS)
			items_sent++;
		if (scored) begin
			score_queue.push_back(known ? known_score : score);
			boards_scored++;
		end
	endtask

	// drained means every score is back and any piece still being summed has finished
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (score_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slopes(input logic [SLOPE_W-1:0] slope_a,
			input logic [SLOPE_W-1:0] slope_b);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SLOPE_FIRST;
		cfg_data  <= slope_a;
		@(posedge clk);
		cfg_index <= CFG_SLOPE_SECOND;
		cfg_data  <= slope_b;
		@(posedge clk);
		cfg_we <= 1'b0;
		slope_first_q  = slope_a;
		slope_second_q = slope_b;
	endtask

	// one white piece per word on the all-max column, last word scores
	task automatic long_board(input int pieces, input bit known, input logic [15:0] score);
		int p;
		for (p = 0; p < pieces; p++)
			send_word(square_item(63, 1'b1, 5, 1'b1, p == pieces - 1), known, score);
	endtask

	task automatic weight_burst();
		int c, r;
		case ($urandom_range(0, 2))
			0: begin
				c = $urandom_range(0, N_IN - 1);
				for (r = 0; r < FH; r++)
					send_word(weight_item(r * N_IN + c, rand_word(), $urandom_range(0, 1)),
						1'b0, '0);
			end
			1: begin
				send_word(weight_item($urandom_range(BIAS1_AT, BIAS3_AT), rand_word(),
					$urandom_range(0, 1)), 1'b0, '0);
			end
			default: begin
				send_word(weight_item($urandom_range(0, 4095), rand_word(),
					$urandom_range(0, 1)), 1'b0, '0);
			end
		endcase
	endtask

	task automatic random_board();
		int          len, s, sq, plane, col;
		bit          pres;
		board_item_t it;
		len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 40);
		for (s = 0; s < len; s++) begin
			// stray weight word in the middle of a board
			if ($urandom_range(0, 99) < 5)
				send_word(weight_item($urandom_range(0, 4095), rand_word(),
					$urandom_range(0, 1)), 1'b0, '0);
			sq    = $urandom_range(0, 63);
			plane = $urandom_range(0, 7);
			pres  = ($urandom_range(0, 9) < 7);
			col   = plane * 64 + sq;
			// a counted piece may only read a column whose rows are all loaded
			if (pres && col < N_IN && !column_ready(col)) begin
				col   = ready_cols[$urandom_range(0, ready_cols.size() - 1)];
				plane = col / 64;
				sq    = col % 64;
			end
			it = square_item(sq, pres, plane, $urandom_range(0, 1), s == len - 1);
			send_word(it, 1'b0, '0);
		end
	endtask

	// output side: random backpressure and score check
	initial begin
		m_tready <= 1'b0;
		stall_left = 0;
		rx_cycle = 0;
		rx_steady = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (score_queue.size() == 0) begin
					report_mismatch($sformatf("score %0d with no board pending",
						$signed(m_tdata)));
				end else begin
					expected_score = score_queue.pop_front();
					if (m_tdata !== expected_score)
						report_mismatch($sformatf("score %0d, expected %0d",
							$signed(m_tdata), $signed(expected_score)));
				end
			end
			rx_cycle++;
			if (rx_cycle % 256 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
			if (rx_steady) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				rx_pick = $urandom_range(0, 99);
				if (rx_pick < 70) begin
					m_tready <= 1'b1;
				end else if (rx_pick < 95) begin
					stall_left = $urandom_range(0, 2);
					m_tready <= 1'b0;
				end else begin
					stall_left = $urandom_range(9, 59);
					m_tready <= 1'b0;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= ACT_WEIGHT;
		s_tlast   <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_SLOPE_FIRST;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		for (k = 0; k < STORE_WORDS; k++) begin
			weight_mem[k] = '0;
			word_written[k] = 1'b0;
		end
		for (k = 0; k < FH; k++)
			hidden_sums[k] = '0;
		slope_first_q  = 13'd410;
		slope_second_q = 13'd410;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// evaluation words start at zero so the first scores read off directly
		for (k = BIAS1_AT; k < STORE_WORDS; k++)
			send_word(weight_item(k, '0, 1'b0), 1'b0, '0);
		foreach (preload_cols[n])
			for (row = 0; row < FH; row++)
				send_word(weight_item(row * N_IN + preload_cols[n],
					(preload_cols[n] == 0) ? 16'h8000 :
					(preload_cols[n] == N_IN - 1) ? 16'h7FFF : rand_word(), 1'b0),
					1'b0, '0);

		// empty board, only bias3 reaches the score
		directed.push_back('{square_item(0, 0, 0, 0, 1), 1'b1, 16'd0});
		directed.push_back('{weight_item(BIAS3_AT, 16'h7FFF, 0), 1'b0, 16'd0});
		// absent piece ignores plane and colour
		directed.push_back('{square_item(63, 0, 7, 1, 1), 1'b1, 16'd799});
		directed.push_back('{weight_item(BIAS3_AT, 16'h8000, 0), 1'b0, 16'd0});
		directed.push_back('{square_item(0, 0, 0, 0, 1), 1'b1, 16'(-800)});
		// writes past the store are dropped, last flag on a weight word means nothing
		directed.push_back('{weight_item(STORE_WORDS, 16'h1234, 1), 1'b0, 16'd0});
		directed.push_back('{weight_item(4095, 16'hFFFF, 1), 1'b0, 16'd0});
		// planes 6 and 7 fall outside the input width
		directed.push_back('{square_item(0, 1, 6, 1, 1), 1'b1, 16'(-800)});
		directed.push_back('{square_item(63, 1, 7, 0, 1), 1'b1, 16'(-800)});
		directed.push_back('{weight_item(BIAS3_AT, 16'h0000, 0), 1'b0, 16'd0});
		directed.push_back('{weight_item(LAYER3_AT, 16'h7FFF, 0), 1'b0, 16'd0});
		directed.push_back('{weight_item(BIAS2_AT, 16'h7FFF, 0), 1'b0, 16'd0});
		directed.push_back('{square_item(31, 0, 3, 1, 1), 1'b0, 16'd0});
		directed.push_back('{weight_item(LAYER2_AT, 16'h1000, 0), 1'b0, 16'd0});
		directed.push_back('{weight_item(BIAS2_AT, 16'h0000, 0), 1'b0, 16'd0});
		directed.push_back('{square_item(0, 1, 0, 1, 0), 1'b0, 16'd0});
		directed.push_back('{square_item(63, 1, 5, 1, 1), 1'b0, 16'd0});
		directed.push_back('{square_item(0, 1, 0, 0, 0), 1'b0, 16'd0});
		directed.push_back('{square_item(63, 1, 5, 1, 1), 1'b0, 16'd0});
		directed.push_back('{square_item(63, 1, 5, 0, 0), 1'b0, 16'd0});
		directed.push_back('{square_item(63, 1, 5, 0, 1), 1'b0, 16'd0});
		foreach (directed[n])
			send_word(directed[n].it, directed[n].known, directed[n].score);
		wait_drained();

		// long boards drive the score into both saturation limits
		idle_on = 1'b0;
		long_board(SAT_PIECES, 1'b1, 16'h7FFF);
		send_word(weight_item(LAYER3_AT, 16'h8000, 0), 1'b0, '0);
		long_board(SAT_PIECES, 1'b1, 16'h8000);
		send_word(weight_item(LAYER3_AT, 16'h7FFF, 0), 1'b0, '0);
		wait_drained();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin sa = 13'd0;    sb = 13'd4096; end
				1: begin sa = 13'd4096; sb = 13'd0;    end
				2: begin sa = 13'd4096; sb = 13'd4096; end
				3: begin sa = 13'd0;    sb = 13'd0;    end
				default: begin
					sa = 13'($urandom_range(0, 4096));
					sb = 13'($urandom_range(0, 4096));
				end
			endcase
			write_slopes(sa, sb);
			start_items  = items_sent;
			start_boards = boards_scored;
			while (items_sent - start_items < PHASE_ITEMS
					|| boards_scored - start_boards < PHASE_SCORES) begin
				idle_on = ($urandom_range(0, 4) != 0);
				if ($urandom_range(0, 99) < 15)
					weight_burst();
				else
					random_board();
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
